[rtl/pc_sample_delta_rle_encoder_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the PC sample delta/RLE encoder
//   Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PC_SAMPLE_DELTA_RLE_ENCODER_UNIT_ASSERT_SVH
`define PC_SAMPLE_DELTA_RLE_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define PCDRE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCDRE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pcdre_pkg.sv]
// ---------------------------------------------------------------------------
// pcdre_pkg
//   Types and constants shared by the PC sample delta/RLE encoder.
// ---------------------------------------------------------------------------
package pcdre_pkg;

    localparam logic [31:0] ISA_THREAD_BASE = 32'd100000;
    localparam logic [31:0] THREAD_RESET    = 32'hffff_fffe;
    localparam logic [7:0]  REPEAT_MARK     = 8'h80;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ISA_ENABLE   = 2'd0;
    localparam logic [1:0] REG_WIN_START    = 2'd1;
    localparam logic [1:0] REG_WIN_END      = 2'd2;
    localparam logic [1:0] REG_TASK_SRC_VLD = 2'd3;

    // result of one 7-bit group step
    typedef struct packed {
        logic [7:0]  data;   // group with stop bit in bit 7
        logic        done;   // this group ends the varint
        logic [31:0] rest;   // remaining value after the shift
    } grp_t;

endpackage

[rtl/pcdre_grp.sv]
// ---------------------------------------------------------------------------
// pcdre_grp
//   Varint group extractor: takes the low 7 bits, tests for the final
//   group and shifts the value right by 7 (logical or arithmetic).
// ---------------------------------------------------------------------------
module pcdre_grp
(
    input  logic [31:0]         value,
    input  logic                signed_mode,
    output pcdre_pkg::grp_t     grp
);
    import pcdre_pkg::*;

    logic fin_u;
    logic fin_s;
    logic fin;

    // signed: bits [31:6] all equal means value fits in this group
    assign fin_u = (value[31:7] == 25'd0);
    assign fin_s = (value[31:6] == {26{value[31]}});
    assign fin   = signed_mode ? fin_s : fin_u;

    always_comb
    begin
        grp.done = fin;
        grp.data = {fin, value[6:0]};
        grp.rest = {{7{signed_mode & value[31]}}, value[31:7]};
    end

endmodule

[rtl/pc_sample_delta_rle_encoder_unit.sv]
// ---------------------------------------------------------------------------
// pc_sample_delta_rle_encoder_unit
//   Encodes profiler PC samples as PC deltas with run-length repeats and
//   thread changes, emitted as a varint byte stream.
// ---------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in      | in        | in_valid / in_stall  | sample_pc, thread_id, isa_task
//   out     | out       | out_valid / out_stall| out_byte, last_byte
//   cfg     | in        | APB psel/penable    | paddr, pwdata, prdata
//
//   A sample that repeats the last one emits nothing and the next may
//   follow at once. Otherwise one byte per cycle leaves the shared group
//   shifter while out_stall is low, 1 to 16 bytes set by the byte count
//   (repeat flush, delta, thread).
//   out_stall holds the sequencer; in_stall is high until the last byte
//   is in the output register.
//   Reset: previous PC 0, previous thread 0xfffffffe, repeat count 0.
// ---------------------------------------------------------------------------
`include "pc_sample_delta_rle_encoder_unit_assert.svh"

module pc_sample_delta_rle_encoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // input samples
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample_pc,
    input  logic [31:0] thread_id,
    input  logic [7:0]  isa_task,
    // byte stream
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pcdre_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MARK = 3'd1;
    localparam logic [2:0] ST_REP  = 3'd2;
    localparam logic [2:0] ST_SVAR = 3'd3;
    localparam logic [2:0] ST_TVAR = 3'd4;

    logic        isa_enable_reg;
    logic [31:0] win_start_reg;
    logic [31:0] win_end_reg;
    logic        task_src_reg;

    logic [31:0] prev_pc_reg;
    logic [31:0] prev_thread_reg;
    logic [31:0] repeat_reg;

    logic [2:0]  state_reg,  state_next;
    logic [31:0] work_reg,   work_next;
    logic [31:0] diff_reg;
    logic [31:0] tid_reg;
    logic        tchg_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg,  out_byte_next;
    logic        last_reg,      last_next;

    logic        cfg_wr;
    logic        in_acc;
    logic [31:0] pc_c;
    logic        in_win;
    logic [31:0] tid_c;
    logic        tchg_c;
    logic [31:0] diff_c;
    logic        adv;
    grp_t        grp;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isa_enable_reg <= 1'b0;
            win_start_reg  <= '0;
            win_end_reg    <= '0;
            task_src_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ISA_ENABLE:   isa_enable_reg <= pwdata[0];
                REG_WIN_START:    win_start_reg  <= pwdata;
                REG_WIN_END:      win_end_reg    <= pwdata;
                REG_TASK_SRC_VLD: task_src_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ISA_ENABLE:   prdata = {31'd0, isa_enable_reg};
            REG_WIN_START:    prdata = win_start_reg;
            REG_WIN_END:      prdata = win_end_reg;
            REG_TASK_SRC_VLD: prdata = {31'd0, task_src_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------- sample front end ----------------
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid & ~in_stall;

    assign pc_c   = {sample_pc[31:1], 1'b0};
    assign in_win = isa_enable_reg & (pc_c > win_start_reg) & (pc_c < win_end_reg);

    always_comb
    begin
        if (in_win)
            tid_c = task_src_reg ? (ISA_THREAD_BASE + {24'd0, isa_task}) : ISA_THREAD_BASE;
        else
            tid_c = thread_id;
    end

    assign tchg_c = (tid_c != prev_thread_reg);
    assign diff_c = (pc_c - prev_pc_reg) | {31'd0, tchg_c};

    // ---------------- shared group shifter ----------------
    pcdre_grp u_grp
    (
        .value       (work_reg),
        .signed_mode (state_reg == ST_SVAR),
        .grp         (grp)
    );

    assign adv = (state_reg != ST_IDLE) & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        state_next    = state_reg;
        work_next     = work_reg;
        out_byte_next = grp.data;
        last_next     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                out_byte_next = grp.data;
            end
            ST_MARK:
            begin
                out_byte_next = REPEAT_MARK;
                state_next    = ST_REP;
            end
            ST_REP:
            begin
                if (grp.done)
                begin
                    work_next  = diff_reg;
                    state_next = ST_SVAR;
                end
                else
                    work_next = grp.rest;
            end
            ST_SVAR:
            begin
                if (grp.done)
                begin
                    if (tchg_reg)
                    begin
                        work_next  = tid_reg;
                        state_next = ST_TVAR;
                    end
                    else
                    begin
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                    work_next = grp.rest;
            end
            ST_TVAR:
            begin
                if (grp.done)
                begin
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    work_next = grp.rest;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- state and history ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prev_pc_reg     <= '0;
            prev_thread_reg <= THREAD_RESET;
            repeat_reg      <= '0;
        end
        else if (in_acc)
        begin
            prev_pc_reg <= pc_c;
            if (tchg_c)
                prev_thread_reg <= tid_c;
            priority if (diff_c == 32'd0)
            begin
                if (repeat_reg != 32'hffff_ffff)
                    repeat_reg <= repeat_reg + 32'd1;
            end
            else if (repeat_reg != 32'd0)
            begin
                repeat_reg <= '0;
                state_reg  <= ST_MARK;
            end
            else
                state_reg <= ST_SVAR;
        end
        else if (adv)
            state_reg <= state_next;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            diff_reg <= diff_c;
            tid_reg  <= tid_c;
            tchg_reg <= tchg_c;
            work_reg <= (repeat_reg != 32'd0) ? repeat_reg : diff_c;
        end
        else if (adv)
            work_reg <= work_next;
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg <= out_byte_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;

    // ---------------- assertions ----------------
    `PCDRE_ASSERT_NXT(a_repeat_no_stall, in_acc && (diff_c == 32'd0), !in_stall,
        "repeated sample must not stall the input")
    `PCDRE_ASSERT_NXT(a_emit_stalls, in_acc && (diff_c != 32'd0), in_stall,
        "emitting sample must occupy the sequencer")
    `PCDRE_ASSERT_IMP(a_last_has_stop, out_valid && last_byte, out_byte[7],
        "final beat must carry the varint stop bit")
    `PCDRE_ASSERT_IMP(a_rep_cleared, (state_reg == ST_REP) || (state_reg == ST_MARK),
        repeat_reg == 32'd0, "repeat count not cleared during flush")

endmodule
